/* hdl/fent_pkg.sv */
// Shared types and constants for the fixed-entry name table.
// No dependencies; imported by fent_match and fixed_entry_name_table.
`timescale 1ns / 1ps
`default_nettype none

package fent_pkg;

    localparam int NAME_BYTES = 14;
    localparam int NAME_W     = 8 * NAME_BYTES;
    localparam int INODE_W    = 16;
    localparam int ENTRY_W    = INODE_W + NAME_W;
    localparam logic [7:0] SLASH_CHAR = 8'h2F;
    localparam logic [3:0] NAME_MAX   = 4'(NAME_BYTES);

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_ITER   = 2'd3
    } cmd_e_t;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_NOTFOUND = 3'd1,
        STAT_BADLEN   = 3'd2,
        STAT_SLASH    = 3'd3,
        STAT_FULL     = 3'd4,
        STAT_END      = 3'd5
    } status_e_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_e_t;

    // search key held for the duration of one command
    typedef struct packed {
        cmd_e_t                  cmd;
        logic [NAME_W-1:0]       name;
        logic [NAME_BYTES-1:0]   cmp_mask;  // bytes that take part in the compare
        logic [3:0]              cap;       // effective max name length
    } key_t;

    typedef struct packed {
        logic                    hit;
        logic [3:0]              name_len;
        logic [NAME_W-1:0]       name;      // stored name masked to cap
    } match_t;

endpackage

`default_nettype wire

/* hdl/fent_mem.sv */
// Entry store: one write port, one registered read port.
// Standalone; instantiated by fixed_entry_name_table.
`timescale 1ns / 1ps
`default_nettype none

module fent_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 128
) (
    input  wire logic          clk,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hdl/fent_match.sv */
// Per-entry compare: decides whether a read entry satisfies the command,
// and forms the masked name and its length. Uses fent_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fent_match (
    input  wire fent_pkg::key_t                    key,
    input  wire logic [fent_pkg::INODE_W-1:0]      inode,
    input  wire logic [fent_pkg::NAME_W-1:0]       name,
    output fent_pkg::match_t                       result
);
    import fent_pkg::*;

    logic [NAME_BYTES-1:0] byte_ok;
    logic                  name_eq;
    logic                  used;

    always_comb
    begin
        result.name     = '0;
        result.name_len = key.cap;
        for (int i = 0; i < NAME_BYTES; i++)
        begin
            byte_ok[i] = !key.cmp_mask[i] || (name[8*i +: 8] == key.name[8*i +: 8]);
            if (4'(i) < key.cap)
            begin
                result.name[8*i +: 8] = name[8*i +: 8];
            end
        end
        // first zero byte below cap sets the length
        for (int i = NAME_BYTES - 1; i >= 0; i--)
        begin
            if ((4'(i) < key.cap) && (name[8*i +: 8] == 8'h00))
            begin
                result.name_len = 4'(i);
            end
        end
        name_eq = &byte_ok;
        used    = (inode != '0);
        case (key.cmd)
            CMD_ADD:  result.hit = !used;
            CMD_ITER: result.hit = used;
            default:  result.hit = used && name_eq;
        endcase
    end

endmodule

`default_nettype wire

/* hdl/fixed_entry_name_table.sv */
// Fixed-entry directory name table: command sequencer around the entry store.
// Depends on fent_pkg, fent_mem and fent_match.
// One command at a time: a new word is taken only in the idle state. A command that scans
// reads the slots one by one through the single read port of the entry store (at most
// ENTRIES slots), compares each registered entry and then offers its result from the done
// state; rejected adds and empty ranges go straight to the done state. A stalled result holds it there.
// Reset clears the slot count and control state; entries hold no reset value
// and are only read after an add has written them. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module fixed_entry_name_table #(
    parameter int ENTRIES = 64
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // command words
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // name_head, name_tail, name_length, inode_number, start_slot, zero pad
    input  wire logic [143:0] s_axis_tdata,
    // cmd
    input  wire logic [1:0]   s_axis_tuser,
    // result words
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // found_inode, slot_index, out_name_head, out_name_tail, out_name_length,
    // next_slot, zero pad
    output logic [151:0]      m_axis_tdata,
    // status
    output logic [2:0]        m_axis_tuser,
    // max_name_length
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [3:0]   cfg_data
);
    import fent_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int SW = (CW > 7) ? CW : 7;

    // input unpack
    logic [NAME_W-1:0]  in_name;
    logic [3:0]         in_len;
    logic [INODE_W-1:0] in_inode;
    logic [6:0]         in_start;
    cmd_e_t             in_cmd;

    assign in_name  = s_axis_tdata[111:0];
    assign in_len   = s_axis_tdata[115:112];
    assign in_inode = s_axis_tdata[131:116];
    assign in_start = s_axis_tdata[138:132];
    assign in_cmd   = cmd_e_t'(s_axis_tuser);

    state_e_t state_reg, state_next;

    logic [3:0]          max_len_reg;
    logic [CW-1:0]       used_reg, used_next;
    key_t                key_reg, key_next;
    logic [INODE_W-1:0]  inode_reg, inode_next;

    logic [IW-1:0]       rd_addr_reg, rd_addr_next;
    logic                rd_more_reg, rd_more_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                cmp_last_reg, cmp_last_next;

    status_e_t           res_status_reg, res_status_next;
    logic [INODE_W-1:0]  res_inode_reg, res_inode_next;
    logic [IW-1:0]       res_slot_reg, res_slot_next;
    logic [NAME_W-1:0]   res_name_reg, res_name_next;
    logic [3:0]          res_len_reg, res_len_next;
    logic [6:0]          res_nxt_reg, res_nxt_next;
    logic                res_wr_reg, res_wr_next;
    logic                res_clr_reg, res_clr_next;
    logic                res_grow_reg, res_grow_next;

    logic                out_vld_reg, out_vld_next;
    status_e_t           out_status_reg;
    logic [INODE_W-1:0]  out_inode_reg;
    logic [5:0]          out_slot_reg;
    logic [NAME_W-1:0]   out_name_reg;
    logic [3:0]          out_len_reg;
    logic [6:0]          out_nxt_reg;

    // accept-side key preparation
    logic [NAME_W-1:0]     acc_name;
    logic [3:0]            acc_n;
    logic [3:0]            acc_e;
    logic [3:0]            acc_cap;
    logic [NAME_BYTES-1:0] acc_mask;
    logic                  acc_slash;

    logic                  in_fire;
    logic                  out_free;
    logic                  mem_rd_en;
    logic [ENTRY_W-1:0]    mem_rd_data;
    logic                  mem_wr_en;
    logic [ENTRY_W-1:0]    mem_wr_data;
    match_t                match;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_vld_reg || m_axis_tready;
    assign acc_cap  = (max_len_reg > NAME_MAX) ? NAME_MAX : max_len_reg;
    assign acc_n    = (in_len > NAME_MAX) ? NAME_MAX : in_len;

    always_comb
    begin
        acc_name  = '0;
        acc_e     = NAME_MAX;
        acc_slash = 1'b0;
        for (int i = 0; i < NAME_BYTES; i++)
        begin
            if (4'(i) < acc_n)
            begin
                acc_name[8*i +: 8] = in_name[8*i +: 8];
            end
        end
        for (int i = NAME_BYTES - 1; i >= 0; i--)
        begin
            if (acc_name[8*i +: 8] == 8'h00)
            begin
                acc_e = 4'(i);
            end
        end
        for (int i = 0; i < NAME_BYTES; i++)
        begin
            // the terminating zero is compared as well
            acc_mask[i] = (4'(i) < acc_cap) && (4'(i) <= acc_e);
            if ((4'(i) < acc_e) && (acc_name[8*i +: 8] == SLASH_CHAR))
            begin
                acc_slash = 1'b1;
            end
        end
    end

    fent_mem #(
        .DEPTH (ENTRIES),
        .AW    (IW),
        .DW    (ENTRY_W)
    ) u_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (rd_addr_reg),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (res_slot_reg),
        .wr_data (mem_wr_data)
    );

    fent_match u_match (
        .key    (key_reg),
        .inode  (mem_rd_data[ENTRY_W-1:NAME_W]),
        .name   (mem_rd_data[NAME_W-1:0]),
        .result (match)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_cmd == CMD_ITER)
                    begin
                        state_next = (SW'(in_start) >= SW'(used_reg)) ? ST_DONE : ST_SCAN;
                    end
                    else if (in_cmd == CMD_ADD)
                    begin
                        if ((acc_e == 4'd0) || (acc_e > acc_cap) || acc_slash ||
                            (used_reg == '0))
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                    else
                    begin
                        state_next = (used_reg == '0) ? ST_DONE : ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (cmp_vld_reg && (match.hit || cmp_last_reg))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        mem_rd_en     = (state_reg == ST_SCAN) && rd_more_reg;
        // write-back happens in the closing cycle, so no later read can overlap it
        mem_wr_en     = (state_reg == ST_DONE) && out_free && res_wr_reg;
        mem_wr_data   = res_clr_reg ? '0 : {inode_reg, key_reg.name};
    end

    // datapath
    always_comb
    begin
        used_next       = used_reg;
        key_next        = key_reg;
        inode_next      = inode_reg;
        rd_addr_next    = rd_addr_reg;
        rd_more_next    = rd_more_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        cmp_last_next   = cmp_last_reg;
        res_status_next = res_status_reg;
        res_inode_next  = res_inode_reg;
        res_slot_next   = res_slot_reg;
        res_name_next   = res_name_reg;
        res_len_next    = res_len_reg;
        res_nxt_next    = res_nxt_reg;
        res_wr_next     = res_wr_reg;
        res_clr_next    = res_clr_reg;
        res_grow_next   = res_grow_reg;
        out_vld_next    = out_vld_reg && !m_axis_tready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    key_next.cmd      = in_cmd;
                    key_next.name     = acc_name;
                    key_next.cmp_mask = acc_mask;
                    key_next.cap      = acc_cap;
                    inode_next        = in_inode;
                    rd_addr_next      = (in_cmd == CMD_ITER) ? IW'(in_start) : '0;
                    rd_more_next      = 1'b1;
                    res_status_next   = STAT_OK;
                    res_inode_next    = '0;
                    res_slot_next     = '0;
                    res_name_next     = '0;
                    res_len_next      = '0;
                    res_nxt_next      = '0;
                    res_wr_next       = 1'b0;
                    res_clr_next      = 1'b0;
                    res_grow_next     = 1'b0;
                    case (in_cmd)
                        CMD_ITER:
                        begin
                            res_status_next = STAT_END;
                            res_nxt_next    = in_start;
                        end
                        CMD_ADD:
                        begin
                            if ((acc_e == 4'd0) || (acc_e > acc_cap))
                            begin
                                res_status_next = STAT_BADLEN;
                            end
                            else if (acc_slash)
                            begin
                                res_status_next = STAT_SLASH;
                            end
                            else if (used_reg == '0)
                            begin
                                // empty directory: append at slot zero
                                res_wr_next   = 1'b1;
                                res_grow_next = 1'b1;
                            end
                        end
                        default: res_status_next = STAT_NOTFOUND;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (rd_more_reg)
                begin
                    cmp_vld_next  = 1'b1;
                    cmp_idx_next  = rd_addr_reg;
                    cmp_last_next = ((CW'(rd_addr_reg) + CW'(1)) == used_reg);
                    rd_more_next  = !((CW'(rd_addr_reg) + CW'(1)) == used_reg);
                    rd_addr_next  = rd_addr_reg + IW'(1);
                end
                if (cmp_vld_reg && (match.hit || cmp_last_reg))
                begin
                    cmp_vld_next = 1'b0;
                    rd_more_next = 1'b0;
                    if (match.hit)
                    begin
                        res_status_next = STAT_OK;
                        res_slot_next   = cmp_idx_reg;
                        case (key_reg.cmd)
                            CMD_ADD:
                            begin
                                res_wr_next = 1'b1;
                            end
                            CMD_REMOVE:
                            begin
                                res_inode_next = mem_rd_data[ENTRY_W-1:NAME_W];
                                res_wr_next    = 1'b1;
                                res_clr_next   = 1'b1;
                            end
                            CMD_ITER:
                            begin
                                res_inode_next = mem_rd_data[ENTRY_W-1:NAME_W];
                                res_name_next  = match.name;
                                res_len_next   = match.name_len;
                                res_nxt_next   = 7'(CW'(cmp_idx_reg) + CW'(1));
                            end
                            default:
                            begin
                                res_inode_next = mem_rd_data[ENTRY_W-1:NAME_W];
                            end
                        endcase
                    end
                    else if (key_reg.cmd == CMD_ADD)
                    begin
                        // no free slot inside the directory: append if room
                        if (used_reg < CW'(ENTRIES))
                        begin
                            res_status_next = STAT_OK;
                            res_slot_next   = IW'(used_reg);
                            res_wr_next     = 1'b1;
                            res_grow_next   = 1'b1;
                        end
                        else
                        begin
                            res_status_next = STAT_FULL;
                        end
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_vld_next = 1'b1;
                    if (res_grow_reg)
                    begin
                        used_next = used_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                out_vld_next = out_vld_reg && !m_axis_tready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            max_len_reg <= NAME_MAX;
            used_reg    <= '0;
            rd_more_reg <= 1'b0;
            cmp_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            rd_more_reg <= rd_more_next;
            cmp_vld_reg <= cmp_vld_next;
            out_vld_reg <= out_vld_next;
            if (cfg_valid && cfg_ready)
            begin
                max_len_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        inode_reg      <= inode_next;
        rd_addr_reg    <= rd_addr_next;
        cmp_idx_reg    <= cmp_idx_next;
        cmp_last_reg   <= cmp_last_next;
        res_status_reg <= res_status_next;
        res_inode_reg  <= res_inode_next;
        res_slot_reg   <= res_slot_next;
        res_name_reg   <= res_name_next;
        res_len_reg    <= res_len_next;
        res_nxt_reg    <= res_nxt_next;
        res_wr_reg     <= res_wr_next;
        res_clr_reg    <= res_clr_next;
        res_grow_reg   <= res_grow_next;
        if ((state_reg == ST_DONE) && out_free)
        begin
            out_status_reg <= res_status_reg;
            out_inode_reg  <= res_inode_reg;
            out_slot_reg   <= 6'(res_slot_reg);
            out_name_reg   <= res_name_reg;
            out_len_reg    <= res_len_reg;
            out_nxt_reg    <= res_nxt_reg;
        end
    end

    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {7'd0, out_nxt_reg, out_len_reg, out_name_reg,
                            out_slot_reg, out_inode_reg};

endmodule

`default_nettype wire

/* dv/fent_reply_check.sv */
// Checker for the fixed-entry name table: watches the command, result and
// length-register channels, keeps its own copy of the directory and compares.
// Depends on fent_pkg for the command and status codes.
`timescale 1ns / 1ps
`default_nettype none

module fent_reply_check
    import fent_pkg::*;
#(
    parameter int SLOTS = 64
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    input  wire logic         s_axis_tready,
    // name_head, name_tail, name_length, inode_number, start_slot, zero pad
    input  wire logic [143:0] s_axis_tdata,
    // cmd
    input  wire logic [1:0]   s_axis_tuser,
    input  wire logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // found_inode, slot_index, out_name_head, out_name_tail, out_name_length,
    // next_slot, zero pad
    input  wire logic [151:0] m_axis_tdata,
    // status
    input  wire logic [2:0]   m_axis_tuser,
    input  wire logic         cfg_valid,
    input  wire logic         cfg_ready,
    input  wire logic [3:0]   cfg_data,
    output int                fail_count,
    output int                replies_owed,
    output int                replies_seen,
    output int                full_seen
);

    typedef struct packed {
        status_e_t          status;
        logic [INODE_W-1:0] inode;
        logic [5:0]         slot;
        logic [63:0]        name_head;
        logic [47:0]        name_tail;
        logic [3:0]         name_len;
        logic [6:0]         next_slot;
    } dir_reply_t;

    logic [INODE_W-1:0] slot_ino [SLOTS];
    logic [NAME_W-1:0]  slot_nm  [SLOTS];
    int unsigned        slots_used;
    logic [3:0]         name_cap;
    dir_reply_t         dir_replies_due [$];

    // first used slot whose name agrees with key over m bytes, else -1
    function automatic int find_entry(logic [NAME_W-1:0] key, int unsigned m);
        logic same;
        for (int s = 0; s < int'(slots_used); s++) begin
            if (slot_ino[s] != '0) begin
                same = 1'b1;
                for (int i = 0; i < int'(m); i++) begin
                    if (key[8*i +: 8] == 8'h00) begin
                        same = (slot_nm[s][8*i +: 8] == 8'h00);
                        break;
                    end
                    if (slot_nm[s][8*i +: 8] != key[8*i +: 8]) begin
                        same = 1'b0;
                        break;
                    end
                end
                if (same)
                    return s;
            end
        end
        return -1;
    endfunction

    // applies one command word to the directory copy, returns its result word
    function automatic dir_reply_t dir_reply(cmd_e_t c, logic [143:0] w);
        dir_reply_t        r;
        logic [NAME_W-1:0] key;
        logic [NAME_W-1:0] shown;
        int unsigned       n, e, m, st, pick, cnt;
        int                hit;
        logic              slash;
        r = '0;
        m = (name_cap > NAME_MAX) ? NAME_BYTES : name_cap;
        n = (w[115:112] > NAME_MAX) ? NAME_BYTES : w[115:112];
        key = '0;
        for (int i = 0; i < NAME_BYTES; i++)
            if (i < int'(n))
                key[8*i +: 8] = w[8*i +: 8];
        e = 0;
        while (e < NAME_BYTES && key[8*e +: 8] != 8'h00)
            e++;
        case (c)
            CMD_LOOKUP, CMD_REMOVE: begin
                hit = find_entry(key, m);
                if (hit < 0)
                    r.status = STAT_NOTFOUND;
                else begin
                    r.inode = slot_ino[hit];
                    r.slot  = 6'(hit);
                    if (c == CMD_REMOVE) begin
                        slot_ino[hit] = '0;
                        slot_nm[hit]  = '0;
                    end
                end
            end
            CMD_ADD: begin
                slash = 1'b0;
                for (int i = 0; i < NAME_BYTES; i++)
                    if (i < int'(e) && key[8*i +: 8] == SLASH_CHAR)
                        slash = 1'b1;
                // length is checked before the slash
                if (e == 0 || e > m)
                    r.status = STAT_BADLEN;
                else if (slash)
                    r.status = STAT_SLASH;
                else begin
                    pick = SLOTS;
                    for (int s = 0; s < int'(slots_used); s++)
                        if (pick == SLOTS && slot_ino[s] == '0)
                            pick = s;
                    if (pick == SLOTS && slots_used < SLOTS) begin
                        pick = slots_used;
                        slots_used++;
                    end
                    if (pick == SLOTS)
                        r.status = STAT_FULL;
                    else begin
                        // an inode of zero is written but leaves the slot free
                        slot_ino[pick] = w[131:116];
                        slot_nm[pick]  = key;
                        r.slot         = 6'(pick);
                    end
                end
            end
            default: begin
                st          = w[138:132];
                r.status    = STAT_END;
                r.next_slot = w[138:132];
                for (int s = 0; s < int'(slots_used); s++) begin
                    if (s >= int'(st) && slot_ino[s] != '0 && r.status == STAT_END) begin
                        shown = '0;
                        for (int k = 0; k < int'(m); k++)
                            shown[8*k +: 8] = slot_nm[s][8*k +: 8];
                        cnt = 0;
                        while (cnt < m && shown[8*cnt +: 8] != 8'h00)
                            cnt++;
                        r.status    = STAT_OK;
                        r.inode     = slot_ino[s];
                        r.slot      = 6'(s);
                        r.name_head = shown[63:0];
                        r.name_tail = shown[111:64];
                        r.name_len  = 4'(cnt);
                        r.next_slot = 7'(s + 1);
                    end
                end
            end
        endcase
        return r;
    endfunction

    function automatic string reply_text(dir_reply_t r);
        return $sformatf("status %0d inode %h slot %0d name %h_%h len %0d next %0d",
                         r.status, r.inode, r.slot, r.name_tail, r.name_head,
                         r.name_len, r.next_slot);
    endfunction

    always @(posedge clk or negedge rst_n) begin
        dir_reply_t got;
        dir_reply_t want;
        if (!rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                slot_ino[s] = '0;
                slot_nm[s]  = '0;
            end
            slots_used = 0;
            name_cap   = NAME_MAX;
            dir_replies_due.delete();
            fail_count   = 0;
            replies_owed = 0;
            replies_seen = 0;
            full_seen    = 0;
        end
        else begin
            if (cfg_valid && cfg_ready)
                name_cap = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                dir_replies_due.push_back(dir_reply(cmd_e_t'(s_axis_tuser), s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                got.status    = status_e_t'(m_axis_tuser);
                got.inode     = m_axis_tdata[15:0];
                got.slot      = m_axis_tdata[21:16];
                got.name_head = m_axis_tdata[85:22];
                got.name_tail = m_axis_tdata[133:86];
                got.name_len  = m_axis_tdata[137:134];
                got.next_slot = m_axis_tdata[144:138];
                replies_seen++;
                if (got.status == STAT_FULL)
                    full_seen++;
                if (dir_replies_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result word with no command pending: %s", reply_text(got));
                end
                else begin
                    want = dir_replies_due.pop_front();
                    if (got.status !== want.status || got.inode !== want.inode ||
                        got.slot !== want.slot || got.name_head !== want.name_head ||
                        got.name_tail !== want.name_tail ||
                        got.name_len !== want.name_len ||
                        got.next_slot !== want.next_slot) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("result word %0d mismatch at %0t", replies_seen, $realtime);
                            $display("  expected %s", reply_text(want));
                            $display("  actual   %s", reply_text(got));
                        end
                    end
                end
            end
            replies_owed = dir_replies_due.size();
        end
    end

endmodule

`default_nettype wire

/* dv/tb_fixed_entry_name_table.sv */
// Testbench top for the fixed-entry name table: drives command words and the
// length register, stalls the result channel, and reports the verdict.
// Depends on fent_pkg, fixed_entry_name_table and fent_reply_check.
`timescale 1ns / 1ps
`default_nettype none

module tb_fixed_entry_name_table;
    import fent_pkg::*;

    localparam int SLOTS  = 64;
    localparam int POOL   = 24;
    localparam int PHASES = 7;
    localparam int PHASE_CAP   [PHASES] = '{8, 1, 15, 0, 11, 14, 3};
    localparam int PHASE_ITEMS [PHASES] = '{300, 250, 200, 120, 300, 300, 230};
    // "ab", a zero, then "cd": the stored name ends at the zero
    localparam logic [NAME_W-1:0] SPLIT_NAME = 112'h64_63_00_62_61;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [151:0] m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [3:0]   cfg_data;

    int   fail_count;
    int   replies_owed;
    int   replies_seen;
    int   full_seen;
    logic quiet_run;
    int   cmd_sent [4];

    logic [NAME_W-1:0] pool_name [POOL];
    logic [3:0]        pool_len  [POOL];

    fixed_entry_name_table #(
        .ENTRIES (SLOTS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    fent_reply_check #(
        .SLOTS (SLOTS)
    ) u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .replies_owed  (replies_owed),
        .replies_seen  (replies_seen),
        .full_seen     (full_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("timeout with %0d results outstanding", replies_owed);
        $display("tb_fixed_entry_name_table NOT OK");
        $finish;
    end

    // result channel back-pressure
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_axis_tready <= quiet_run || ($urandom_range(0, 99) >= 25);
        end
    end

    function automatic logic [NAME_W-1:0] text_name(string s);
        logic [NAME_W-1:0] v;
        v = '0;
        for (int i = 0; i < s.len() && i < NAME_BYTES; i++)
            v[8*i +: 8] = s[i];
        return v;
    endfunction

    // one command word; returns at the edge where it is taken
    task automatic send(cmd_e_t c, logic [NAME_W-1:0] name, logic [3:0] len,
                        logic [INODE_W-1:0] ino, logic [6:0] start);
        @(negedge clk);
        while (!quiet_run && $urandom_range(0, 99) < 25)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, start, ino, len, name};
        s_axis_tuser  <= c;
        cmd_sent[c]++;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // length register is only written with nothing in flight
    task automatic set_cap(logic [3:0] v);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (replies_owed != 0)
            @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // mostly pool names so lookups and removes hit; some noise and broken names
    task automatic random_command();
        int                 pick;
        int                 roll;
        int                 k;
        logic [127:0]       junk;
        logic [NAME_W-1:0]  name;
        logic [3:0]         len;
        logic [INODE_W-1:0] ino;
        cmd_e_t             c;
        pick = $urandom_range(0, POOL - 1);
        name = pool_name[pick];
        len  = pool_len[pick];
        roll = $urandom_range(0, 99);
        if (roll < 15)
        begin
            junk = {$urandom, $urandom, $urandom, $urandom};
            name = junk[NAME_W-1:0];
            len  = 4'($urandom_range(0, 15));
        end
        else if (roll < 27)
        begin
            // bytes past the length must be masked off
            for (int i = 0; i < NAME_BYTES; i++)
                if (i >= int'(len))
                    name[8*i +: 8] = 8'($urandom);
        end
        else if (roll < 34)
            len = 4'($urandom_range(len, 15));
        else if (roll < 39)
        begin
            k = $urandom_range(0, len - 1);
            name[8*k +: 8] = SLASH_CHAR;
        end
        roll = $urandom_range(0, 99);
        if (roll < 40)
            c = CMD_ADD;
        else if (roll < 65)
            c = CMD_LOOKUP;
        else if (roll < 80)
            c = CMD_REMOVE;
        else
            c = CMD_ITER;
        ino = ($urandom_range(0, 99) < 5) ? '0 : INODE_W'($urandom);
        send(c, name, len, ino, 7'($urandom_range(0, SLOTS)));
    endtask

    initial
    begin
        int drain;
        rst_n         = 1'b0;
        quiet_run     = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_LOOKUP;
        cfg_valid     = 1'b0;
        cfg_data      = NAME_MAX;
        cmd_sent      = '{default: 0};

        // short names in the pool keep small length settings busy
        for (int p = 0; p < POOL; p++)
        begin
            pool_len[p]  = (p < 4) ? 4'd1 : (p < 8) ? 4'($urandom_range(2, 4))
                                                    : 4'($urandom_range(1, 14));
            pool_name[p] = '0;
            for (int i = 0; i < int'(pool_len[p]); i++)
            begin
                pool_name[p][8*i +: 8] = 8'($urandom_range(1, 255));
                if (pool_name[p][8*i +: 8] == SLASH_CHAR)
                    pool_name[p][8*i +: 8] = 8'h2E;
            end
        end

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // empty directory, rejected adds, free-slot reuse, split names
        send(CMD_ITER, '0, 4'd0, '0, 7'd0);
        send(CMD_LOOKUP, text_name("a"), 4'd1, '0, 7'd0);
        send(CMD_REMOVE, text_name("a"), 4'd1, '0, 7'd0);
        send(CMD_ADD, text_name("a"), 4'd0, 16'h1234, 7'd0);
        send(CMD_ADD, '1, 4'd15, 16'hFFFF, 7'd64);
        send(CMD_ADD, text_name("usr/bin"), 4'd7, 16'h0042, 7'd0);
        send(CMD_ADD, SPLIT_NAME, 4'd5, 16'h0001, 7'd0);
        send(CMD_ADD, text_name("zz"), 4'd2, 16'h0000, 7'd0);
        send(CMD_ADD, text_name("q"), 4'd1, 16'h8000, 7'd0);
        send(CMD_LOOKUP, '1, 4'd14, '0, 7'd0);
        send(CMD_LOOKUP, text_name("ab"), 4'd2, '0, 7'd0);
        send(CMD_ITER, '0, 4'd0, '0, 7'd1);
        send(CMD_ITER, '0, 4'd0, '0, 7'd64);
        send(CMD_REMOVE, text_name("ab"), 4'd2, '0, 7'd0);
        send(CMD_ITER, '0, 4'd0, '0, 7'd1);
        send(CMD_ADD, 112'h01, 4'd1, 16'h0001, 7'd0);
        send(CMD_ADD, '0, 4'd5, 16'h0005, 7'd0);
        // truncated compare and capped iterate
        set_cap(4'd8);
        send(CMD_LOOKUP, '1, 4'd14, '0, 7'd0);
        send(CMD_ADD, text_name("longername10"), 4'd12, 16'h0777, 7'd0);
        send(CMD_ADD, text_name("eightchr"), 4'd8, 16'h0888, 7'd0);
        send(CMD_ITER, '0, 4'd0, '0, 7'd0);
        set_cap(4'd15);
        send(CMD_ITER, '0, 4'd0, '0, 7'd0);
        send(CMD_LOOKUP, text_name("eightchr"), 4'd8, '0, 7'd0);
        // zero length: everything matches, nothing can be added
        set_cap(4'd0);
        send(CMD_LOOKUP, text_name("x"), 4'd1, '0, 7'd0);
        send(CMD_ADD, text_name("x"), 4'd1, 16'h0005, 7'd0);
        send(CMD_REMOVE, text_name("x"), 4'd1, '0, 7'd0);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            set_cap(4'(PHASE_CAP[ph]));
            quiet_run <= (ph == 4);
            repeat (PHASE_ITEMS[ph]) random_command();
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        quiet_run     <= 1'b0;
        for (drain = 0; drain < 20000 && replies_owed != 0; drain++)
            @(negedge clk);
        repeat (80) @(negedge clk);

        $display("sent %0d lookups, %0d adds, %0d removes, %0d iterates over lengths 0..15",
                 cmd_sent[CMD_LOOKUP], cmd_sent[CMD_ADD], cmd_sent[CMD_REMOVE],
                 cmd_sent[CMD_ITER]);
        $display("checked %0d result words, %0d of them table full, %0d mismatches",
                 replies_seen, full_seen, fail_count);
        if (replies_owed != 0)
            $display("%0d result words never arrived", replies_owed);
        if (fail_count == 0 && replies_owed == 0)
            $display("tb_fixed_entry_name_table OK");
        else
            $display("tb_fixed_entry_name_table NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
